// File: design/pba_pkg.sv
package pba_pkg;

	localparam int unsigned SIZE_W = 17;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned PAGE_IDX_W = 6;
	localparam int unsigned STATUS_W = 2;

	localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = 17'd4096;
	localparam logic [SIZE_W-1:0] PAGE_SIZE_MIN = 17'd64;
	localparam logic [SIZE_W-1:0] PAGE_SIZE_MAX = 17'd65536;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef struct packed {
		logic action;
		logic [SIZE_W-1:0] request_size;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_IDX_W-1:0] page_index;
		logic [OFFSET_W-1:0] byte_offset;
		logic opened_page;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

endpackage

// File: design/paged_bump_allocator.sv
// Release or oversized request: S_IDLE goes straight to S_DONE, then rsp_valid rises;
// allocate: S_READ, then S_CHECK for each page scanned (1 .. pages in use), then S_DONE.
// Throughput: one item at a time; the scan reads one page offset per cycle from a
// single-port offset RAM, and a new item is taken only after the last response is registered.
// Reset: page size 4096, one page in use with its offset at the header end;
// other RAM entries are written when their page opens, no clearing pass.
module paged_bump_allocator
	import pba_pkg::*;
#(
	parameter int unsigned MAX_PAGES = 64,
	parameter int unsigned HEADER_BYTES = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data,
	input  logic cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata
);

	localparam int unsigned IW = $clog2(MAX_PAGES);
	localparam int unsigned PW = $clog2(MAX_PAGES + 1);
	localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
	localparam logic [PW-1:0] FULL_CNT = PW'(MAX_PAGES);

	state_t state_q, state_d;
	logic [SIZE_W-1:0] page_size_q;
	logic [PW-1:0] pages_q;
	logic fresh0_q;
	logic [IW-1:0] idx_q;
	logic [SIZE_W-1:0] size_q;
	rsp_t res_q, rsp_q;
	logic rsp_valid_q;

	logic mem_en, mem_we;
	logic [IW-1:0] mem_addr;
	logic [SIZE_W-1:0] mem_wdata, mem_rdata;

	logic req_xfer, out_free, oversize, fits, last, full;
	logic [SIZE_W-1:0] payload, used, cfg_clamped;

	pba_offset_ram #(
		.DEPTH(MAX_PAGES),
		.WIDTH(SIZE_W)
	) u_ram (
		.clk(clk),
		.en(mem_en),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer = req_valid && (state_q == S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign payload = page_size_q - HDR;
	assign oversize = req_data.request_size > payload;

	// page 0 reads as fresh until its first write after a reinit
	assign used = (idx_q == '0 && fresh0_q) ? HDR : mem_rdata;
	assign fits = (used <= page_size_q) && (size_q <= page_size_q - used);
	assign last = (idx_q == '0);
	assign full = (pages_q == FULL_CNT);

	always_comb begin
		if (cfg_wdata < PAGE_SIZE_MIN) begin
			cfg_clamped = PAGE_SIZE_MIN;
		end else if (cfg_wdata > PAGE_SIZE_MAX) begin
			cfg_clamped = PAGE_SIZE_MAX;
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					if (req_data.action == ACT_RELEASE || oversize) begin
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: state_d = S_CHECK;
			S_CHECK: begin
				if (fits || last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_en = 1'b0;
		mem_we = 1'b0;
		mem_addr = idx_q;
		mem_wdata = used + size_q;
		case (state_q)
			S_READ: begin
				mem_en = 1'b1;
			end
			S_CHECK: begin
				if (fits) begin
					mem_en = 1'b1;
					mem_we = 1'b1;
				end else if (!last) begin
					mem_en = 1'b1;
					mem_addr = idx_q - 1'b1;
				end else if (!full) begin
					mem_en = 1'b1;
					mem_we = 1'b1;
					mem_addr = IW'(pages_q);
					mem_wdata = HDR + size_q;
				end
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			page_size_q <= PAGE_SIZE_RESET;
			pages_q <= PW'(1);
			fresh0_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (req_xfer && req_data.action == ACT_RELEASE) begin
				pages_q <= PW'(1);
				fresh0_q <= 1'b1;
			end
			if (state_q == S_CHECK) begin
				if (fits) begin
					if (last) begin
						fresh0_q <= 1'b0;
					end
				end else if (last && !full) begin
					pages_q <= pages_q + 1'b1;
				end
			end
			if (cfg_we) begin
				page_size_q <= cfg_clamped;
				pages_q <= PW'(1);
				fresh0_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			idx_q <= IW'(pages_q - 1'b1);
			size_q <= req_data.request_size;
			res_q <= '{(req_data.action == ACT_ALLOC && oversize) ? ST_TOO_BIG : ST_OK,
				'0, '0, 1'b0};
		end
		if (state_q == S_CHECK) begin
			if (fits) begin
				res_q.status <= ST_OK;
				res_q.page_index <= PAGE_IDX_W'(idx_q);
				res_q.byte_offset <= used[OFFSET_W-1:0];
				res_q.opened_page <= 1'b0;
			end else if (!last) begin
				idx_q <= idx_q - 1'b1;
			end else if (full) begin
				res_q <= '{ST_NO_PAGE, '0, '0, 1'b0};
			end else begin
				res_q.status <= ST_OK;
				res_q.page_index <= PAGE_IDX_W'(pages_q);
				res_q.byte_offset <= HDR[OFFSET_W-1:0];
				res_q.opened_page <= 1'b1;
			end
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule

// File: design/pba_offset_ram.sv
module pba_offset_ram
	import pba_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 17
) (
	input  logic clk,
	input  logic en,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pba_pkg::*;

	localparam int unsigned POOL_PAGES = 64;
	localparam int unsigned HDR_BYTES = 24;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned SCAN_SLACK = POOL_PAGES + 16;
	localparam int unsigned PHASE_ITEMS = 200;
	localparam int unsigned NUM_PHASES = 8;

	class alloc_scoreboard;
		logic [SIZE_W-1:0] page_size;
		logic [SIZE_W-1:0] offset_tbl [POOL_PAGES];
		int unsigned pages_open;
		rsp_t expected_grants [$];
		int unsigned errors;
		int unsigned n_grant, n_opened, n_too_big, n_no_page, n_release, n_checked;

		function void fresh_pool();
			foreach (offset_tbl[i])
				offset_tbl[i] = SIZE_W'(HDR_BYTES);
			pages_open = 1;
		endfunction

		function void set_page_size(logic [SIZE_W-1:0] v);
			page_size = v;
			if (v < PAGE_SIZE_MIN)
				page_size = PAGE_SIZE_MIN;
			if (v > PAGE_SIZE_MAX)
				page_size = PAGE_SIZE_MAX;
			fresh_pool();
		endfunction

		function rsp_t predict_grant(req_t r);
			rsp_t g;
			int unsigned payload, want, used;
			int p;
			g = '0;
			g.status = ST_OK;
			if (r.action == ACT_RELEASE) begin
				fresh_pool();
				n_release++;
				return g;
			end
			payload = page_size - HDR_BYTES;
			want = r.request_size;
			if (want > payload) begin
				g.status = ST_TOO_BIG;
				n_too_big++;
				return g;
			end
			// newest page first
			for (p = int'(pages_open) - 1; p >= 0; p--) begin
				used = offset_tbl[p];
				if (used <= page_size && want <= page_size - used) begin
					g.page_index = PAGE_IDX_W'(p);
					g.byte_offset = OFFSET_W'(used);
					offset_tbl[p] = SIZE_W'(used + want);
					n_grant++;
					return g;
				end
			end
			if (pages_open >= POOL_PAGES) begin
				g.status = ST_NO_PAGE;
				n_no_page++;
				return g;
			end
			offset_tbl[pages_open] = SIZE_W'(HDR_BYTES + want);
			g.page_index = PAGE_IDX_W'(pages_open);
			g.byte_offset = OFFSET_W'(HDR_BYTES);
			g.opened_page = 1'b1;
			pages_open++;
			n_grant++;
			n_opened++;
			return g;
		endfunction

		function void note_request(req_t r);
			expected_grants.push_back(predict_grant(r));
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_grant(rsp_t got);
			rsp_t exp_g;
			n_checked++;
			if (expected_grants.size() == 0) begin
				report_mismatch($sformatf("unexpected response %p", got));
			end else begin
				exp_g = expected_grants.pop_front();
				if (got.status !== exp_g.status)
					report_mismatch($sformatf("status exp %0d got %0d",
						exp_g.status, got.status));
				if (got.page_index !== exp_g.page_index)
					report_mismatch($sformatf("page_index exp %0d got %0d",
						exp_g.page_index, got.page_index));
				if (got.byte_offset !== exp_g.byte_offset)
					report_mismatch($sformatf("byte_offset exp %0d got %0d",
						exp_g.byte_offset, got.byte_offset));
				if (got.opened_page !== exp_g.opened_page)
					report_mismatch($sformatf("opened_page exp %0d got %0d",
						exp_g.opened_page, got.opened_page));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	alloc_scoreboard sb;
	bit idle_on;
	bit hold_rsp;
	int unsigned quiet_cycles;
	int unsigned n_sizes;

	paged_bump_allocator #(
		.MAX_PAGES(POOL_PAGES),
		.HEADER_BYTES(HDR_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly no gap or a short one, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// receive side: random stall runs, plus one long hold-off on request
	initial begin
		int unsigned run_left;
		bit stalling;
		bit held;
		run_left = 0;
		stalling = 1'b0;
		held = 1'b0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.check_grant(rsp_data);
			@(negedge clk);
			if (hold_rsp && !held) begin
				held = 1'b1;
				rsp_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_stall = 1'b0;
				run_left = 0;
			end else if (!idle_on) begin
				rsp_stall = 1'b0;
			end else begin
				if (run_left == 0) begin
					stalling = ($urandom_range(0, 2) == 0);
					run_left = stalling ? pick_gap() + 1 : $urandom_range(1, 10);
				end
				rsp_stall = stalling;
				run_left--;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic act, input logic [SIZE_W-1:0] size);
		req_t r;
		int unsigned gap;
		r.action = act;
		r.request_size = size;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_data = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic alloc(input logic [SIZE_W-1:0] size);
		send_item(ACT_ALLOC, size);
	endtask

	// sender goes quiet until every pending response is back
	task automatic drain();
		req_valid = 1'b0;
		while (sb.expected_grants.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_page_size(input logic [SIZE_W-1:0] v);
		drain();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(posedge clk);
		sb.set_page_size(v);
		n_sizes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_item();
		int unsigned payload, chunk, r;
		payload = sb.page_size - HDR_BYTES;
		r = $urandom_range(0, 99);
		if (r < 2)
			send_item(ACT_RELEASE, SIZE_W'($urandom_range(0, 17'h1FFFF)));
		else if (r < 8)
			alloc(SIZE_W'($urandom_range(payload + 1, 17'h1FFFF)));
		else if (r < 12)
			alloc('0);
		else if (r < 18)
			alloc(SIZE_W'(payload));
		else begin
			chunk = payload >> $urandom_range(0, 6);
			alloc(SIZE_W'($urandom_range(0, chunk)));
		end
	endtask

	initial begin
		logic [SIZE_W-1:0] phase_sizes [NUM_PHASES];
		sb = new();
		sb.page_size = PAGE_SIZE_RESET;
		sb.fresh_pool();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_on = 1'b1;
		hold_rsp = 1'b0;
		n_sizes = 1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset page size: zero-byte, full page, oversize, new page, release
		alloc('0);
		alloc(SIZE_W'(PAGE_SIZE_RESET - HDR_BYTES));
		alloc('0);
		alloc(SIZE_W'(PAGE_SIZE_RESET - HDR_BYTES + 1));
		alloc(17'h1FFFF);
		alloc(17'd1);
		send_item(ACT_RELEASE, 17'h1FFFF);
		alloc(17'd100);

		// below the minimum acts as the smallest page
		write_page_size('0);
		alloc(17'd40);
		alloc(17'd41);
		alloc(17'd40);
		alloc('0);
		alloc(17'd17);
		send_item(ACT_RELEASE, '0);

		// above the maximum acts as the largest page; offset wraps at the page end
		write_page_size(17'h1FFFF);
		alloc(17'd65512);
		alloc('0);
		alloc(17'd65513);
		alloc(17'd65536);
		alloc(17'd1);
		send_item(ACT_RELEASE, 17'd65536);

		phase_sizes = '{17'd64, 17'd65536, PAGE_SIZE_RESET,
			SIZE_W'($urandom_range(65, 2000)), 17'd100, 17'd3, 17'h18000,
			SIZE_W'($urandom_range(64, 65536))};
		foreach (phase_sizes[ph]) begin
			write_page_size(phase_sizes[ph]);
			idle_on = (ph % 3 != 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 1 && i == 50)
					hold_rsp = 1'b1;
				if (ph == 3 && i == 100)
					drain();
				random_item();
			end
		end

		drain();
		repeat (SCAN_SLACK) @(posedge clk);
		$display("covered %0d transfers over %0d page sizes: %0d grants, %0d new pages,",
			sb.n_checked, n_sizes, sb.n_grant, sb.n_opened);
		$display("  %0d oversize, %0d pool full, %0d releases",
			sb.n_too_big, sb.n_no_page, sb.n_release);
		if (sb.errors == 0 && sb.expected_grants.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
